// ===== hdl/dsq_pkg.sv =====
// Shared constants, request codes and the controller/datapath link types
// of the delta-list sleep queue. Depends on nothing.
`default_nettype none

package dsq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int DELAY_BITS  = 32;

  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [DELAY_BITS-1:0] DELAY_MAX = '1;

  localparam logic [1:0] REQ_INSERT  = 2'd0;
  localparam logic [1:0] REQ_TICK    = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;
  localparam logic [1:0] REQ_WAKE    = 2'd3;

  typedef logic [DELAY_BITS-1:0] delay_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // latch request fields
    logic tick;   // decrement head offset
    logic walk;   // one insert walk step
    logic put;    // place new entry, fix successor
    logic scan;   // one release scan step
    logic fin;    // capture post-release head
    logic emit;   // drive one result
    logic woken;  // result releases the head entry
    logic wake;   // wake-all flavour of pop/emit
    logic pop;    // shift list down by one
    logic last;   // final result of the request
  } dsq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic walk_go;
    logic scan_go;
    logic pos_zero;
    logic pos_one;
    logic cnt_zero;
    logic cnt_one;
  } dsq_stat_t;

endpackage

`default_nettype wire

// ===== hdl/dsq_dpath.sv =====
// Datapath of the sleep queue: offset and thread registers, walk pointer,
// remaining-delay register and result registers. Depends on dsq_pkg.
`default_nettype none

module dsq_dpath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire dsq_pkg::dsq_cmd_t cmd,
  output dsq_pkg::dsq_stat_t   stat,
  input  wire logic [1:0]      req_type,
  input  wire logic [7:0]      thread_id,
  input  wire logic [31:0]     duration,
  input  wire logic [1:0]      cause,
  output logic                 strobe,
  output logic                 woken_valid,
  output logic [7:0]           woken_thread,
  output logic                 cause_set,
  output logic [1:0]           cause_out,
  output logic [31:0]          head_delay,
  output logic                 queue_empty,
  output logic                 overflow,
  output logic                 last
);
  import dsq_pkg::*;

  function automatic delay_t to_delay(input logic [31:0] d);
    logic [63:0] w;
    w = 64'(d);
    if (w > 64'(DELAY_MAX)) return DELAY_MAX;
    return DELAY_BITS'(w);
  endfunction

  function automatic delay_t sat_add(input delay_t a, input delay_t b);
    logic [DELAY_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s[DELAY_BITS]) return DELAY_MAX;
    return s[DELAY_BITS-1:0];
  endfunction

  function automatic logic [31:0] to_out(input delay_t d);
    logic [63:0] w;
    w = 64'(d);
    return w[31:0];
  endfunction

  delay_t     delta [QUEUE_DEPTH];
  logic [7:0] tids  [QUEUE_DEPTH];
  cnt_t       count;
  cnt_t       pos;
  delay_t     rem;
  logic [7:0] new_tid;
  logic [1:0] cause_q;
  logic       ovf;
  delay_t     fin_head;
  logic       fin_empty;

  delay_t     rd_delta;
  delay_t     succ_diff;
  logic       pos_in;
  delay_t     live_head;
  logic       head_nz;

  assign rd_delta  = delta[pos[IDX_BITS-1:0]];
  assign succ_diff = rd_delta - rem;
  assign pos_in    = pos < count;
  assign live_head = (count != '0) ? delta[0] : '0;
  assign head_nz   = delta[0] != '0;

  assign stat.full     = count == cnt_t'(QUEUE_DEPTH);
  assign stat.walk_go  = pos_in && (rd_delta <= rem);
  assign stat.scan_go  = pos_in && (rd_delta == '0);
  assign stat.pos_zero = pos == '0;
  assign stat.pos_one  = pos == cnt_t'(1);
  assign stat.cnt_zero = count == '0;
  assign stat.cnt_one  = count == cnt_t'(1);

  // list storage: shifts read fixed neighbours only
  always_ff @(posedge clk) begin
    if (cmd.put) begin
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
        if (cnt_t'(i) == pos + cnt_t'(1)) begin
          delta[i] <= succ_diff;
          tids[i]  <= tids[i-1];
        end else if (cnt_t'(i) > pos) begin
          delta[i] <= delta[i-1];
          tids[i]  <= tids[i-1];
        end else if (cnt_t'(i) == pos) begin
          delta[i] <= rem;
          tids[i]  <= new_tid;
        end
      end
      if (pos == '0) begin
        delta[0] <= rem;
        tids[0]  <= new_tid;
      end
    end else if (cmd.pop) begin
      for (int i = 1; i < QUEUE_DEPTH - 1; i++) begin
        delta[i] <= delta[i+1];
      end
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        tids[i] <= tids[i+1];
      end
      // wake-all carries the popped offset onto the new head
      delta[0] <= cmd.wake ? sat_add(delta[1], delta[0]) : delta[1];
    end else if (cmd.tick && count != '0 && head_nz) begin
      delta[0] <= delta[0] - delay_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.put) begin
      count <= count + cnt_t'(1);
    end else if (cmd.pop) begin
      count <= count - cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos     <= '0;
      rem     <= to_delay(duration);
      new_tid <= thread_id;
      cause_q <= cause;
      ovf     <= (req_type == REQ_INSERT) && stat.full;
    end else if (cmd.walk) begin
      pos <= pos + cnt_t'(1);
      rem <= rem - rd_delta;
    end else if (cmd.scan) begin
      pos <= pos + cnt_t'(1);
    end else if (cmd.pop) begin
      pos <= pos - cnt_t'(1);
    end
    if (cmd.fin) begin
      fin_empty <= !pos_in;
      fin_head  <= pos_in ? rd_delta : '0;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      woken_valid  <= cmd.woken;
      woken_thread <= cmd.woken ? tids[0] : 8'd0;
      cause_set    <= cmd.woken && cmd.wake && head_nz;
      cause_out    <= (cmd.woken && cmd.wake && head_nz) ? cause_q : 2'd0;
      overflow     <= ovf;
      last         <= cmd.last;
      if (!cmd.woken) begin
        head_delay  <= to_out(live_head);
        queue_empty <= count == '0;
      end else if (cmd.wake) begin
        head_delay  <= 32'd0;
        queue_empty <= 1'b1;
      end else begin
        head_delay  <= to_out(fin_head);
        queue_empty <= fin_empty;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dsq_ctrl.sv =====
// Sequencer of the sleep queue: request decode, insert walk, release scan
// and pop loops. Depends on dsq_pkg.
`default_nettype none

module dsq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [1:0]         req_type,
  input  wire dsq_pkg::dsq_stat_t stat,
  output dsq_pkg::dsq_cmd_t       cmd,
  output logic                    busy
);
  import dsq_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_WALK     = 3'd1;
  localparam logic [2:0] S_PUT      = 3'd2;
  localparam logic [2:0] S_STATUS   = 3'd3;
  localparam logic [2:0] S_SCAN     = 3'd4;
  localparam logic [2:0] S_REL_POP  = 3'd5;
  localparam logic [2:0] S_WAKE_POP = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (req_type)
            REQ_INSERT:  state_next = stat.full ? S_STATUS : S_WALK;
            REQ_TICK: begin
              cmd.tick   = 1'b1;
              state_next = S_STATUS;
            end
            REQ_RELEASE: state_next = S_SCAN;
            REQ_WAKE:    state_next = S_WAKE_POP;
            default:     state_next = S_STATUS;
          endcase
        end
      end
      S_WALK: begin
        if (stat.walk_go) begin
          cmd.walk = 1'b1;
        end else begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        cmd.put    = 1'b1;
        state_next = S_STATUS;
      end
      S_STATUS: begin
        cmd.emit   = 1'b1;
        cmd.last   = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        if (stat.scan_go) begin
          cmd.scan = 1'b1;
        end else begin
          cmd.fin    = 1'b1;
          state_next = stat.pos_zero ? S_STATUS : S_REL_POP;
        end
      end
      S_REL_POP: begin
        cmd.emit  = 1'b1;
        cmd.woken = 1'b1;
        cmd.pop   = 1'b1;
        cmd.last  = stat.pos_one;
        if (stat.pos_one) state_next = S_IDLE;
      end
      S_WAKE_POP: begin
        if (stat.cnt_zero) begin
          state_next = S_STATUS;
        end else begin
          cmd.emit  = 1'b1;
          cmd.woken = 1'b1;
          cmd.wake  = 1'b1;
          cmd.pop   = 1'b1;
          cmd.last  = stat.cnt_one;
          if (stat.cnt_one) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/delta_sleep_queue.sv =====
// Top level of the delta-list sleep queue: sequencer plus datapath.
// Depends on dsq_pkg, dsq_ctrl and dsq_dpath.
//
// A request is taken when start is high and busy is low; busy then stays
// high until the request's last result has been registered. Results come
// out one per cycle on strobe and cannot be held off, so the receiver must
// take each one in the cycle it appears; a request's results are always
// back to back and the final one carries last. A tick or a dropped insert
// goes straight to its single status result; an insert walks the offset
// list one entry per cycle; a release scans the zero-offset prefix one
// entry per cycle and then pops one entry per cycle; a wake-all pops one
// entry per cycle. busy drops in the cycle the last result shows, so a new
// request may be taken in that same cycle. The single offset read port of
// the walk/scan pointer is what paces the insert walk and the release scan.
`default_nettype none

module delta_sleep_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type,
  input  wire logic [7:0]  thread_id,
  input  wire logic [31:0] duration,
  input  wire logic [1:0]  cause,
  output logic             strobe,
  output logic             woken_valid,
  output logic [7:0]       woken_thread,
  output logic             cause_set,
  output logic [1:0]       cause_out,
  output logic [31:0]      head_delay,
  output logic             queue_empty,
  output logic             overflow,
  output logic             last
);
  import dsq_pkg::*;

  dsq_cmd_t  cmd;
  dsq_stat_t stat;

  // request sequencing; start is only looked at while idle
  dsq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  // offset list, walk state and result registers
  dsq_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req_type     (req_type),
    .thread_id    (thread_id),
    .duration     (duration),
    .cause        (cause),
    .strobe       (strobe),
    .woken_valid  (woken_valid),
    .woken_thread (woken_thread),
    .cause_set    (cause_set),
    .cause_out    (cause_out),
    .head_delay   (head_delay),
    .queue_empty  (queue_empty),
    .overflow     (overflow),
    .last         (last)
  );

  // a request's results run without gaps until last
  a_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("result burst broken before last");

  // a taken request holds busy on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after request");

  // a status-only result is always the sole result of its request
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !woken_valid |-> last)
    else $error("status result not marked last");

  // cause only tags released threads
  a_cause: assert property (@(posedge clk) disable iff (rst)
    strobe && cause_set |-> woken_valid)
    else $error("cause set without release");

  // empty queue reports no head delay
  a_empty: assert property (@(posedge clk) disable iff (rst)
    strobe && queue_empty |-> head_delay == 32'd0)
    else $error("head delay nonzero on empty queue");

endmodule

`default_nettype wire

// ===== bench/delta_sleep_queue_tb.sv =====
// Self-checking bench for delta_sleep_queue: random bursts of sleep, tick,
// release and wake-all requests, results checked against an in-bench model.
// Depends on dsq_pkg and the delta_sleep_queue RTL.

module delta_sleep_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dsq_pkg::*;

  // Rough request count; directed part comes first.
  localparam int REQ_TARGET = 470;
  // Cycles with neither a request taken nor a result seen before giving up.
  localparam int STALL_LIMIT = 1000;
  // Drain time after the last expected result, to catch stray strobes.
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  tid;
    logic [31:0] dur;
    logic [1:0]  cause;
  } sleep_req_t;

  typedef struct {
    logic        valid;
    logic [7:0]  tid;
    logic        cset;
    logic [1:0]  cval;
    logic [31:0] head;
    logic        empty;
    logic        ovf;
    logic        last;
  } wakeup_t;

  logic        clk;
  logic        rst;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type = REQ_TICK;
  logic [7:0]  thread_id = '0;
  logic [31:0] duration = '0;
  logic [1:0]  cause = '0;
  logic        strobe;
  logic        woken_valid;
  logic [7:0]  woken_thread;
  logic        cause_set;
  logic [1:0]  cause_out;
  logic [31:0] head_delay;
  logic        queue_empty;
  logic        overflow;
  logic        last;

  delta_sleep_queue dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .thread_id   (thread_id),
    .duration    (duration),
    .cause       (cause),
    .strobe      (strobe),
    .woken_valid (woken_valid),
    .woken_thread(woken_thread),
    .cause_set   (cause_set),
    .cause_out   (cause_out),
    .head_delay  (head_delay),
    .queue_empty (queue_empty),
    .overflow    (overflow),
    .last        (last)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------
  // Shadow of the sleep list: offsets relative to the previous entry,
  // head at index 0. Only entries below sleepers are ever touched.
  // ---------------------------------------------------------------------
  logic [31:0] shadow_delay [QUEUE_DEPTH];
  logic [7:0]  shadow_tid   [QUEUE_DEPTH];
  int          sleepers = 0;

  sleep_req_t  pending_reqs [$];
  wakeup_t     wakeups_due  [$];
  sleep_req_t  cur_req;
  int          planned_reqs = 0;
  int          reqs_taken = 0;
  int          mismatches = 0;
  int          burst_left = 1;
  int          gap_left = 0;
  int          idle_cycles = 0;

  function automatic void push_wakeup(logic valid, logic [7:0] tid, logic cset,
                                      logic [1:0] cval);
    wakeup_t w;
    w.valid = valid;
    w.tid   = tid;
    w.cset  = cset;
    w.cval  = cval;
    w.head  = '0;
    w.empty = 1'b0;
    w.ovf   = 1'b0;
    w.last  = 1'b0;
    wakeups_due.push_back(w);
  endfunction

  // Drop the head entry, shifting the rest down.
  function automatic void pop_sleeper();
    for (int i = 1; i < sleepers; i++) begin
      shadow_delay[i-1] = shadow_delay[i];
      shadow_tid[i-1]   = shadow_tid[i];
    end
    sleepers--;
  endfunction

  // Works out the results of one accepted request and updates the shadow.
  function automatic void predict_wakeups(sleep_req_t rq);
    logic [31:0] acc;
    logic [31:0] off;
    logic [32:0] sum;
    logic        dropped;
    int          pos;
    int          first;
    first   = wakeups_due.size();
    dropped = 1'b0;
    case (rq.kind)
      REQ_INSERT: begin
        if (sleepers >= QUEUE_DEPTH) begin
          dropped = 1'b1;
        end else begin
          // walk past every entry due no later than the new one
          acc = '0;
          pos = 0;
          while (pos < sleepers && shadow_delay[pos] <= rq.dur - acc) begin
            acc = acc + shadow_delay[pos];
            pos++;
          end
          off = rq.dur - acc;
          for (int i = sleepers; i > pos; i--) begin
            shadow_delay[i] = shadow_delay[i-1];
            shadow_tid[i]   = shadow_tid[i-1];
          end
          shadow_delay[pos] = off;
          shadow_tid[pos]   = rq.tid;
          sleepers++;
          if (pos + 1 < sleepers)
            shadow_delay[pos+1] = shadow_delay[pos+1] - off;
        end
      end
      REQ_TICK: begin
        if (sleepers > 0 && shadow_delay[0] != '0)
          shadow_delay[0] = shadow_delay[0] - 1'b1;
      end
      REQ_RELEASE: begin
        while (sleepers > 0 && shadow_delay[0] == '0) begin
          push_wakeup(1'b1, shadow_tid[0], 1'b0, 2'd0);
          pop_sleeper();
        end
      end
      default: begin
        // wake-all: early wakers get the cause, offsets carry onto the next
        while (sleepers > 0) begin
          off = shadow_delay[0];
          if (off != '0)
            push_wakeup(1'b1, shadow_tid[0], 1'b1, rq.cause);
          else
            push_wakeup(1'b1, shadow_tid[0], 1'b0, 2'd0);
          pop_sleeper();
          if (sleepers > 0) begin
            sum = {1'b0, shadow_delay[0]} + {1'b0, off};
            shadow_delay[0] = sum[32] ? DELAY_MAX : sum[31:0];
          end
        end
      end
    endcase
    if (wakeups_due.size() == first)
      push_wakeup(1'b0, 8'd0, 1'b0, 2'd0);
    for (int k = first; k < wakeups_due.size(); k++) begin
      wakeups_due[k].head  = (sleepers > 0) ? shadow_delay[0] : '0;
      wakeups_due[k].empty = (sleepers == 0);
      wakeups_due[k].ovf   = dropped;
      wakeups_due[k].last  = (k == wakeups_due.size() - 1);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic void add_req(logic [1:0] kind, logic [31:0] dur);
    sleep_req_t rq;
    rq.kind  = kind;
    rq.tid   = 8'($urandom_range(0, 255));
    rq.dur   = dur;
    rq.cause = 2'($urandom_range(0, 3));
    pending_reqs.push_back(rq);
  endfunction

  // Mostly short sleeps so ticks actually expire them; some wide ones.
  function automatic logic [31:0] pick_duration();
    case ($urandom_range(0, 9))
      6, 7:    return 32'($urandom_range(0, 2000));
      8:       return $urandom();
      9:       return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
      default: return 32'($urandom_range(0, 12));
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Driver: one request per handshake, bursts with random gaps in between.
  // A held request stays put while busy is high.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_wakeups(cur_req);
        reqs_taken++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur_req = pending_reqs.pop_front();
          req_type  <= cur_req.kind;
          thread_id <= cur_req.tid;
          duration  <= cur_req.dur;
          cause     <= cur_req.cause;
          start     <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            // occasionally a long unbroken run, else short bursts
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every strobe is a result that must match the oldest one due.
  // ---------------------------------------------------------------------
  function automatic void check_field(string what, logic [31:0] want,
                                      logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    wakeup_t due;
    if (!rst && strobe) begin
      if (wakeups_due.size() == 0) begin
        $display("%0t: result expected none actual thread %0h valid %0b",
                 $time, woken_thread, woken_valid);
        mismatches++;
      end else begin
        due = wakeups_due.pop_front();
        check_field("woken_valid", 32'(due.valid), 32'(woken_valid));
        check_field("woken_thread", 32'(due.tid), 32'(woken_thread));
        check_field("cause_set", 32'(due.cset), 32'(cause_set));
        check_field("cause_out", 32'(due.cval), 32'(cause_out));
        check_field("head_delay", due.head, head_delay);
        check_field("queue_empty", 32'(due.empty), 32'(queue_empty));
        check_field("overflow", 32'(due.ovf), 32'(overflow));
        check_field("last", 32'(due.last), 32'(last));
      end
    end
  end

  // Watchdog: no handshake and no result for too long means a hang.
  always @(posedge clk) begin : watchdog
    if (rst || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Request list, then wait for the drain and give the verdict.
  // ---------------------------------------------------------------------
  initial begin : stimulus
    rst = 1'b1;

    // empty queue: tick, release and wake-all do nothing but report
    add_req(REQ_TICK, pick_duration());
    add_req(REQ_RELEASE, pick_duration());
    add_req(REQ_WAKE, pick_duration());
    // zero sleep: a tick on a zero head saturates, release pops it
    add_req(REQ_INSERT, 32'd0);
    add_req(REQ_TICK, 32'd0);
    add_req(REQ_RELEASE, 32'd0);
    // fill to the brim: longest sleep, a tie, a zero, then random
    add_req(REQ_INSERT, 32'hFFFF_FFFF);
    add_req(REQ_INSERT, 32'd5);
    add_req(REQ_INSERT, 32'd5);
    add_req(REQ_INSERT, 32'd0);
    for (int i = 0; i < QUEUE_DEPTH - 4; i++)
      add_req(REQ_INSERT, 32'($urandom_range(0, 40)));
    // full queue drops the insert and flags it
    add_req(REQ_INSERT, 32'd7);
    add_req(REQ_RELEASE, 32'd0);
    pending_reqs.push_back('{REQ_WAKE, 8'hFF, 32'd0, 2'd3});

    while (pending_reqs.size() < REQ_TARGET) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          // a few sleepers, then time passes with the odd release
          repeat ($urandom_range(1, 5))
            add_req(REQ_INSERT, pick_duration());
          repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 19))
              0:                     add_req(REQ_INSERT, pick_duration());
              1, 2, 3, 4, 5:         add_req(REQ_RELEASE, pick_duration());
              default:               add_req(REQ_TICK, pick_duration());
            endcase
          end
          add_req(REQ_RELEASE, pick_duration());
        end
        6: add_req(REQ_WAKE, pick_duration());
        7: begin
          // noise: any request, any fields
          repeat ($urandom_range(1, 4))
            add_req(2'($urandom_range(0, 3)), $urandom());
        end
        8: begin
          // overrun the queue, then either wake all or try a few releases
          repeat (QUEUE_DEPTH + $urandom_range(0, 3))
            add_req(REQ_INSERT, pick_duration());
          if ($urandom_range(0, 1))
            add_req(REQ_WAKE, pick_duration());
          else
            repeat ($urandom_range(2, 6)) add_req(REQ_RELEASE, pick_duration());
        end
        default: begin
          repeat ($urandom_range(1, 3)) add_req(REQ_RELEASE, pick_duration());
        end
      endcase
    end
    planned_reqs = pending_reqs.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (reqs_taken < planned_reqs);
    while (wakeups_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/dsq_pkg.sv
hdl/dsq_dpath.sv
hdl/dsq_ctrl.sv
hdl/delta_sleep_queue.sv
bench/delta_sleep_queue_tb.sv
